### src/chunked_sector_stream_demux_unit_macros.svh
// Assertion macros for the chunked sector stream demux.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef CHUNKED_SECTOR_STREAM_DEMUX_UNIT_MACROS_SVH
`define CHUNKED_SECTOR_STREAM_DEMUX_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CSDU_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("csdu: invariant violated");

// Same-cycle implication.
`define CSDU_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csdu: implication violated");

// Next-cycle implication.
`define CSDU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csdu: next-cycle implication violated");

`endif

### src/csdu_pkg.sv
// Shared types and constants for the chunked sector stream demux.
// No dependencies.
`timescale 1ns / 1ps

package csdu_pkg;

	localparam int DATA_SLOTS_DEF    = 8;
	localparam int CHUNK_SLOTS_DEF   = 4;
	localparam int AUDIO_SECTORS_DEF = 64;

	localparam int ACTION_W  = 2;
	localparam int WORD_W    = 16;
	localparam int CNT_W     = 16;
	localparam int POS_W     = 24;
	localparam int START_W   = 19;
	localparam int TARGET_W  = 3;
	localparam int SLOT_W    = 8;
	localparam int DLEFT_W   = 5;
	localparam int SECTOR_SH = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = START_W;

	localparam logic [WORD_W-1:0]   TERMINATOR_ID = 16'hFFFF;
	localparam logic [CNT_W-1:0]    CNT_MAX       = 16'hFFFF;
	localparam logic [TARGET_W-1:0] TARGET_RST    = 3'd4;

	localparam logic [ACTION_W-1:0] ACT_DATA    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_OTHER   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TARGET = 1'b1;

	typedef enum logic [2:0] {
		EV_DATA       = 3'd0,
		EV_AUDIO      = 3'd1,
		EV_HEADER     = 3'd2,
		EV_TERMINATOR = 3'd3,
		EV_PAUSED     = 3'd4,
		EV_IGNORED    = 3'd5,
		EV_TRANSFER   = 3'd6,
		EV_FINISHED   = 3'd7
	} event_kind_t;

	typedef struct packed {
		event_kind_t       kind;
		logic [SLOT_W-1:0] slot;
		logic              half;
		logic              pause;
		logic              resume;
		logic [POS_W-1:0]  pos;
	} result_t;

endpackage

### src/csdu_step.sv
// Stream state and per-transaction decision logic of the sector demux.
// Depends on csdu_pkg; assertions from chunked_sector_stream_demux_unit_macros.svh.
`timescale 1ns / 1ps

`include "chunked_sector_stream_demux_unit_macros.svh"

module csdu_step #(
	parameter int DATA_SLOTS    = csdu_pkg::DATA_SLOTS_DEF,
	parameter int CHUNK_SLOTS   = csdu_pkg::CHUNK_SLOTS_DEF,
	parameter int AUDIO_SECTORS = csdu_pkg::AUDIO_SECTORS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csdu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [csdu_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                en,
	input  logic [csdu_pkg::ACTION_W-1:0]       action,
	input  logic [csdu_pkg::WORD_W-1:0]         header_id,
	input  logic [csdu_pkg::WORD_W-1:0]         header_length,
	output csdu_pkg::result_t                   res
);
	import csdu_pkg::*;

	localparam int DSW = $clog2(DATA_SLOTS);
	localparam int CSW = $clog2(CHUNK_SLOTS);
	localparam int AW  = $clog2(AUDIO_SECTORS + 1);
	localparam logic [DSW-1:0] DS_LAST = DSW'(DATA_SLOTS - 1);
	localparam logic [CSW-1:0] CS_LAST = CSW'(CHUNK_SLOTS - 1);
	localparam logic [AW-1:0]  AUDIO_N = AW'(AUDIO_SECTORS);

	logic [DLEFT_W-1:0] data_left_q,   data_left_d;
	logic [AW-1:0]      audio_left_q,  audio_left_d;
	logic [CNT_W-1:0]   chunks_read_q, chunks_read_d;
	logic [CNT_W-1:0]   target_q,      target_d;
	logic [CNT_W-1:0]   chunks_sent_q, chunks_sent_d;
	logic [DSW-1:0]     dslot_q,       dslot_d;
	logic [CSW-1:0]     cslot_q,       cslot_d;
	logic [SLOT_W-1:0]  aslot_q,       aslot_d;
	logic               ended_q,       ended_d;
	logic               reading_q,     reading_d;
	logic [POS_W-1:0]   pos_q,         pos_d;
	logic [DLEFT_W-1:0] hdr_data;
	logic [DSW-1:0]     dslot_inc;

	assign hdr_data  = header_length[SECTOR_SH +: DLEFT_W];
	assign dslot_inc = (dslot_q == DS_LAST) ? '0 : dslot_q + DSW'(1);

	always_comb begin
		data_left_d   = data_left_q;
		audio_left_d  = audio_left_q;
		chunks_read_d = chunks_read_q;
		target_d      = target_q;
		chunks_sent_d = chunks_sent_q;
		dslot_d       = dslot_q;
		cslot_d       = cslot_q;
		aslot_d       = aslot_q;
		ended_d       = ended_q;
		reading_d     = reading_q;
		pos_d         = pos_q;
		res.kind      = EV_IGNORED;
		res.slot      = '0;
		res.half      = 1'b0;
		res.pause     = 1'b0;
		res.resume    = 1'b0;
		if (action == ACT_DATA || action == ACT_OTHER) begin
			if (ended_q) begin
				res.pause = 1'b1;
				reading_d = 1'b0;
			end else if (action == ACT_DATA) begin
				if (data_left_q != '0) begin
					res.kind    = EV_DATA;
					res.slot    = SLOT_W'(dslot_q);
					dslot_d     = dslot_inc;
					data_left_d = data_left_q - DLEFT_W'(1);
				end else if (audio_left_q != '0) begin
					res.kind     = EV_AUDIO;
					res.slot     = aslot_q;
					aslot_d      = aslot_q + SLOT_W'(1);
					audio_left_d = audio_left_q - AW'(1);
				end else if (chunks_read_q < target_q) begin
					res.slot = SLOT_W'(dslot_q);
					dslot_d  = dslot_inc;
					if (header_id == TERMINATOR_ID) begin
						res.kind  = EV_TERMINATOR;
						res.pause = 1'b1;
						ended_d   = 1'b1;
						reading_d = 1'b0;
					end else begin
						res.kind      = EV_HEADER;
						data_left_d   = hdr_data;
						audio_left_d  = AUDIO_N;
						pos_d         = pos_q + POS_W'(1) + POS_W'(hdr_data)
							+ POS_W'(AUDIO_SECTORS);
						chunks_read_d = chunks_read_q + CNT_W'(1);
					end
				end else begin
					res.kind  = EV_PAUSED;
					res.pause = 1'b1;
					reading_d = 1'b0;
				end
			end
		end else if (action == ACT_REQUEST) begin
			if (ended_q && chunks_sent_q > chunks_read_q) begin
				res.kind = EV_FINISHED;
			end else begin
				res.kind      = EV_TRANSFER;
				res.slot      = SLOT_W'(cslot_q);
				res.half      = chunks_sent_q[0];
				chunks_sent_d = chunks_sent_q + CNT_W'(1);
				// slot ring restarts whenever the 16-bit count wraps
				if (chunks_sent_q == CNT_MAX || cslot_q == CS_LAST) begin
					cslot_d = '0;
				end else begin
					cslot_d = cslot_q + CSW'(1);
				end
				if (!ended_q) begin
					target_d = target_q + CNT_W'(1);
					if (!reading_q) begin
						reading_d  = 1'b1;
						res.resume = 1'b1;
					end
				end
			end
		end
		res.pos = pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_left_q   <= '0;
			audio_left_q  <= '0;
			chunks_read_q <= '0;
			target_q      <= CNT_W'(TARGET_RST);
			chunks_sent_q <= '0;
			dslot_q       <= '0;
			cslot_q       <= '0;
			aslot_q       <= '0;
			ended_q       <= 1'b0;
			reading_q     <= 1'b1;
			pos_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_POSITION: pos_q    <= POS_W'(cfg_data);
				CFG_INITIAL_TARGET: target_q <= CNT_W'(cfg_data[TARGET_W-1:0]);
				default: ;
			endcase
		end else if (en) begin
			data_left_q   <= data_left_d;
			audio_left_q  <= audio_left_d;
			chunks_read_q <= chunks_read_d;
			target_q      <= target_d;
			chunks_sent_q <= chunks_sent_d;
			dslot_q       <= dslot_d;
			cslot_q       <= cslot_d;
			aslot_q       <= aslot_d;
			ended_q       <= ended_d;
			reading_q     <= reading_d;
			pos_q         <= pos_d;
		end
	end

	`CSDU_ASSERT_ALWAYS(a_dslot_range, dslot_q <= DS_LAST)
	`CSDU_ASSERT_ALWAYS(a_cslot_range, cslot_q <= CS_LAST)
	`CSDU_ASSERT_IMPLY(a_audio_after_data, data_left_q != '0, audio_left_q == AUDIO_N)
	`CSDU_ASSERT_NEXT(a_pause_stops, en && !cfg_we && res.pause, !reading_q)

endmodule

### src/chunked_sector_stream_demux_unit.sv
// Top level of the chunked sector stream demux: input stage, step logic, result register.
// Depends on csdu_pkg, csdu_step and chunked_sector_stream_demux_unit_macros.svh.
`timescale 1ns / 1ps

// Usage:
//   s_* channel carries drive and playback events: s_tuser is the action
//   (0 data sector ready, 1 other drive interrupt, 2 playback request), s_tdata the
//   first two 16-bit words of the sector (header id, header length).
//   m_* channel returns exactly one result per accepted transaction: m_tuser the
//   event kind, m_tdata the slot, transfer half, drive pause/resume and the
//   sector address of the next chunk header.
//   cfg_we/cfg_index/cfg_data load start_position (index 0) and initial_target
//   (index 1); write only while no transaction is in flight.
// Path: an accepted transaction is captured in the input register, and its result is
//   then captured in the result register, which drives m_*.
// Throughput: one transaction per cycle while m_* is not stalled; the state update
//   is a single pass of counter logic between the input and result registers.
// Reset: all counters clear, the chunk target returns to 4, the drive is
//   considered reading, read position 0; both channels come up empty.
// Stall: while m_tready is low the result holds, one more transaction sits in
//   the input register, and s_tready drops once both are full.

`include "chunked_sector_stream_demux_unit_macros.svh"

module chunked_sector_stream_demux_unit #(
	parameter int DATA_SLOTS    = csdu_pkg::DATA_SLOTS_DEF,
	parameter int CHUNK_SLOTS   = csdu_pkg::CHUNK_SLOTS_DEF,
	parameter int AUDIO_SECTORS = csdu_pkg::AUDIO_SECTORS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csdu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [csdu_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // header_id, header_length
	input  logic [1:0]                     s_tuser,  // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// buffer_slot, transfer_half, drive_pause, drive_resume, read_position, zero pad
	output logic [39:0]                    m_tdata,
	output logic [2:0]                     m_tuser   // event_kind
);
	import csdu_pkg::*;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [WORD_W-1:0]   id_s1;
	logic [WORD_W-1:0]   len_s1;
	logic                out_valid_q;
	result_t             res_q;
	result_t             res;
	logic                advance;
	logic                step_en;

	assign advance  = !out_valid_q || m_tready;
	assign step_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			id_s1     <= s_tdata[15:0];
			len_s1    <= s_tdata[31:16];
		end
	end

	csdu_step #(
		.DATA_SLOTS   (DATA_SLOTS),
		.CHUNK_SLOTS  (CHUNK_SLOTS),
		.AUDIO_SECTORS(AUDIO_SECTORS)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.en           (step_en),
		.action       (action_s1),
		.header_id    (id_s1),
		.header_length(len_s1),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {5'b0, res_q.pos, res_q.resume, res_q.pause, res_q.half, res_q.slot};

	`CSDU_ASSERT_IMPLY(a_no_pause_resume, out_valid_q, !(res_q.pause && res_q.resume))
	`CSDU_ASSERT_IMPLY(a_resume_on_transfer, out_valid_q && res_q.resume, res_q.kind == EV_TRANSFER)
	`CSDU_ASSERT_NEXT(a_out_hold, out_valid_q && !m_tready, out_valid_q)

endmodule
